FILE: rtl/mmawa_pkg.sv
`default_nettype none
package mmawa_pkg;

   localparam int DEF_SAMPLE_BITS  = 12;
   localparam int DEF_WINDOW_STEPS = 5;

   localparam int SAMPLE_W   = 12;
   localparam int VALUE_W    = 16;
   localparam int REL_W      = 2;
   localparam int MODE_W     = 2;
   localparam int LOG2_W     = 3;
   localparam int SCALE_W    = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [VALUE_W-1:0] ACC_MAX = 16'hFFFF;
   localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd1;

   // register indexes
   localparam logic [1:0] REG_STAT_MODE     = 2'd0;
   localparam logic [1:0] REG_WINDOW_LOG2   = 2'd1;
   localparam logic [1:0] REG_AVERAGE_SCALE = 2'd2;

   // statistics modes
   localparam logic [MODE_W-1:0] MODE_MIN = 2'd0;
   localparam logic [MODE_W-1:0] MODE_MAX = 2'd1;
   localparam logic [MODE_W-1:0] MODE_AVG = 2'd2;

   // channel relation codes
   localparam logic [REL_W-1:0] REL_EQUAL     = 2'd0;
   localparam logic [REL_W-1:0] REL_A_GREATER = 2'd1;
   localparam logic [REL_W-1:0] REL_A_LESS    = 2'd2;

   typedef struct packed {
      logic [VALUE_W-1:0] value_a;
      logic [VALUE_W-1:0] value_b;
      logic [REL_W-1:0]   relation;
   } result_type;

endpackage
`default_nettype wire

FILE: rtl/min_max_avg_window_accumulator_unit.sv
// Windowed min / max / scaled average over sample pairs.
// A window's result is valid once its last item has passed the input register,
// then the result register.
// Throughput: one item per cycle; a result held by rsp_stall stops the input
// only while the item in the input register closes a window.
// Reset (synchronous, active high) clears the valids and loads start values.
`default_nettype none
module min_max_avg_window_accumulator_unit
   import mmawa_pkg::*;
#(
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
   parameter int WINDOW_STEPS = DEF_WINDOW_STEPS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [SAMPLE_W-1:0]   req_sample_a,
   input  wire logic [SAMPLE_W-1:0]   req_sample_b,

   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [VALUE_W-1:0]         rsp_value_a,
   output logic [VALUE_W-1:0]         rsp_value_b,
   output logic [REL_W-1:0]           rsp_relation,

   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0]      csr_prdata,
   output logic                       csr_pready
);

   localparam int CNT_W = WINDOW_STEPS;
   localparam logic [LOG2_W-1:0] LOG2_LIM =
      (WINDOW_STEPS - 1 > 4) ? LOG2_W'(4) : LOG2_W'(WINDOW_STEPS - 1);
   localparam int PROD_W = VALUE_W + SCALE_W;

   function automatic logic [LOG2_W-1:0] eff_log2(input logic [LOG2_W-1:0] l);
      return (l > LOG2_LIM) ? LOG2_LIM : l;
   endfunction

   function automatic logic [MODE_W-1:0] eff_mode(input logic [MODE_W-1:0] m);
      return (m == MODE_MIN || m == MODE_MAX || m == MODE_AVG) ? m : MODE_MIN;
   endfunction

   function automatic logic [VALUE_W-1:0] start_acc(input logic [MODE_W-1:0] m);
      return (eff_mode(m) == MODE_MIN) ? ACC_MAX : '0;
   endfunction

   function automatic logic [CNT_W-1:0] window_len(input logic [LOG2_W-1:0] l);
      return CNT_W'(1) << eff_log2(l);
   endfunction

   function automatic logic [VALUE_W-1:0] fold(input logic [MODE_W-1:0]      m,
                                               input logic [VALUE_W-1:0]     acc,
                                               input logic [SAMPLE_BITS-1:0] s);
      logic [VALUE_W-1:0] sx;
      logic [VALUE_W:0]   sum;
      sx  = VALUE_W'(s);
      sum = {1'b0, acc} + {1'b0, sx};
      case (eff_mode(m))
         MODE_MAX: fold = (sx > acc) ? sx : acc;
         MODE_AVG: fold = sum[VALUE_W] ? ACC_MAX : sum[VALUE_W-1:0];
         default:  fold = (sx < acc) ? sx : acc;
      endcase
   endfunction

   function automatic logic [VALUE_W-1:0] finish(input logic [MODE_W-1:0]  m,
                                                 input logic [LOG2_W-1:0]  l,
                                                 input logic [SCALE_W-1:0] scale,
                                                 input logic [VALUE_W-1:0] acc);
      logic [PROD_W-1:0] prod;
      logic [PROD_W-1:0] shifted;
      prod    = PROD_W'(acc) * PROD_W'(scale);
      shifted = prod >> eff_log2(l);
      if (eff_mode(m) != MODE_AVG) begin
         finish = acc;
      end else if (|shifted[PROD_W-1:VALUE_W]) begin
         finish = ACC_MAX;
      end else begin
         finish = shifted[VALUE_W-1:0];
      end
   endfunction

   // configuration registers
   logic [MODE_W-1:0]  mode_ff,  mode_in;
   logic [LOG2_W-1:0]  log2_ff,  log2_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;

   // window state
   logic [VALUE_W-1:0] acc_a_ff, acc_a_in;
   logic [VALUE_W-1:0] acc_b_ff, acc_b_in;
   logic [CNT_W-1:0]   left_ff,  left_in;

   // input stage
   logic                   s_valid_ff, s_valid_in;
   logic [SAMPLE_BITS-1:0] s_a_ff, s_a_in;
   logic [SAMPLE_BITS-1:0] s_b_ff, s_b_in;

   // result stage
   logic       r_valid_ff, r_valid_in;
   result_type r_ff, r_in;

   logic               csr_wr;
   logic [1:0]         csr_idx;
   logic               accept, move, emit, out_free;
   logic [VALUE_W-1:0] fold_a, fold_b, fin_a, fin_b;

   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[3:2];
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_idx)
         REG_STAT_MODE:     csr_prdata = CSR_DATA_W'(mode_ff);
         REG_WINDOW_LOG2:   csr_prdata = CSR_DATA_W'(log2_ff);
         REG_AVERAGE_SCALE: csr_prdata = CSR_DATA_W'(scale_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign out_free  = !r_valid_ff || !rsp_stall;
   assign emit      = (left_ff <= CNT_W'(1));
   assign move      = s_valid_ff && (!emit || out_free);
   assign req_stall = s_valid_ff && !move;
   assign accept    = req_valid && !req_stall;

   assign fold_a = fold(mode_ff, acc_a_ff, s_a_ff);
   assign fold_b = fold(mode_ff, acc_b_ff, s_b_ff);
   assign fin_a  = finish(mode_ff, log2_ff, scale_ff, fold_a);
   assign fin_b  = finish(mode_ff, log2_ff, scale_ff, fold_b);

   always_comb begin
      mode_in  = mode_ff;
      log2_in  = log2_ff;
      scale_in = scale_ff;
      acc_a_in = acc_a_ff;
      acc_b_in = acc_b_ff;
      left_in  = left_ff;

      if (csr_wr) begin
         // mode and window writes restart the window with the new values
         case (csr_idx)
            REG_STAT_MODE: begin
               mode_in  = csr_pwdata[MODE_W-1:0];
               acc_a_in = start_acc(csr_pwdata[MODE_W-1:0]);
               acc_b_in = start_acc(csr_pwdata[MODE_W-1:0]);
               left_in  = window_len(log2_ff);
            end
            REG_WINDOW_LOG2: begin
               log2_in  = csr_pwdata[LOG2_W-1:0];
               acc_a_in = start_acc(mode_ff);
               acc_b_in = start_acc(mode_ff);
               left_in  = window_len(csr_pwdata[LOG2_W-1:0]);
            end
            REG_AVERAGE_SCALE: begin
               scale_in = csr_pwdata[SCALE_W-1:0];
            end
            default: begin
            end
         endcase
      end else if (move) begin
         if (emit) begin
            acc_a_in = start_acc(mode_ff);
            acc_b_in = start_acc(mode_ff);
            left_in  = window_len(log2_ff);
         end else begin
            acc_a_in = fold_a;
            acc_b_in = fold_b;
            left_in  = left_ff - CNT_W'(1);
         end
      end
   end

   always_comb begin
      s_valid_in = s_valid_ff;
      s_a_in     = s_a_ff;
      s_b_in     = s_b_ff;
      if (accept) begin
         s_valid_in = 1'b1;
         s_a_in     = req_sample_a[SAMPLE_BITS-1:0];
         s_b_in     = req_sample_b[SAMPLE_BITS-1:0];
      end else if (move) begin
         s_valid_in = 1'b0;
      end
   end

   always_comb begin
      r_valid_in = r_valid_ff && rsp_stall;
      r_in       = r_ff;
      if (move && emit) begin
         r_valid_in      = 1'b1;
         r_in.value_a    = fin_a;
         r_in.value_b    = fin_b;
         if (fin_a > fin_b) begin
            r_in.relation = REL_A_GREATER;
         end else if (fin_a < fin_b) begin
            r_in.relation = REL_A_LESS;
         end else begin
            r_in.relation = REL_EQUAL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_MIN;
         log2_ff    <= '0;
         scale_ff   <= SCALE_RESET;
         acc_a_ff   <= ACC_MAX;
         acc_b_ff   <= ACC_MAX;
         left_ff    <= CNT_W'(1);
         s_valid_ff <= 1'b0;
         r_valid_ff <= 1'b0;
      end else begin
         mode_ff    <= mode_in;
         log2_ff    <= log2_in;
         scale_ff   <= scale_in;
         acc_a_ff   <= acc_a_in;
         acc_b_ff   <= acc_b_in;
         left_ff    <= left_in;
         s_valid_ff <= s_valid_in;
         r_valid_ff <= r_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s_a_ff <= s_a_in;
      s_b_ff <= s_b_in;
      r_ff   <= r_in;
   end

   assign rsp_valid    = r_valid_ff;
   assign rsp_value_a  = r_ff.value_a;
   assign rsp_value_b  = r_ff.value_b;
   assign rsp_relation = r_ff.relation;

endmodule
`default_nettype wire
